### design/overwriting_ring_buffer_defines.svh
// Assertion macros for the overwriting ring buffer.
`ifndef OVERWRITING_RING_BUFFER_DEFINES_SVH
`define OVERWRITING_RING_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS
`define ORB_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define ORB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ORB_ASSERT(label, clk, rst_n, ante, cons, msg)
`define ORB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### design/orb_pkg.sv
// Shared types and constants of the overwriting ring buffer.
package orb_pkg;

    localparam int DEPTH        = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int USED_DEPTH_W = 5;
    localparam int CMP_W        = (CNT_W > USED_DEPTH_W) ? CNT_W : USED_DEPTH_W;
    localparam int TDATA_W      = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = USED_DEPTH_W;

    localparam logic [CFG_INDEX_W-1:0] REG_USED_DEPTH = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLED    = CFG_INDEX_W'(1);

    localparam logic [USED_DEPTH_W-1:0] USED_DEPTH_RST = USED_DEPTH_W'(16);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_SKIP  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] rd_addr;
        logic             rd_hit;
    } orb_mem_req_t;

endpackage

### design/orb_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module orb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/orb_ctrl.sv
// Pointer, wrap flag and configuration registers of the ring buffer.
module orb_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  orb_pkg::op_t                        op,
    input  logic                                cfg_wr_en,
    input  logic [orb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [orb_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    output orb_pkg::orb_mem_req_t               mem_req
);

    localparam int IDX_W = orb_pkg::IDX_W;
    localparam int CMP_W = orb_pkg::CMP_W;

    logic [IDX_W-1:0]                  wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]                  rd_ptr_reg, rd_ptr_next;
    logic                              wrapped_reg, wrapped_next;
    logic [orb_pkg::USED_DEPTH_W-1:0]  used_depth_reg;
    logic                              enabled_reg;

    logic [CMP_W-1:0] ud;
    logic [CMP_W-1:0] n;
    logic [CMP_W-1:0] w0;
    logic [CMP_W-1:0] r0;
    logic [CMP_W-1:0] w_inc;
    logic [CMP_W-1:0] r_inc;
    logic             unread;
    logic             wr_en;
    logic             rd_hit;

    always_comb begin
        ud = CMP_W'(used_depth_reg);
        if (ud == '0) begin
            n = CMP_W'(1);
        end else if (ud > CMP_W'(orb_pkg::DEPTH)) begin
            n = CMP_W'(orb_pkg::DEPTH);
        end else begin
            n = ud;
        end
        w0 = (CMP_W'(wr_ptr_reg) >= n) ? '0 : CMP_W'(wr_ptr_reg);
        r0 = (CMP_W'(rd_ptr_reg) >= n) ? '0 : CMP_W'(rd_ptr_reg);
        w_inc  = w0 + CMP_W'(1);
        r_inc  = r0 + CMP_W'(1);
        unread = wrapped_reg || (w0 > r0);

        wr_ptr_next  = IDX_W'(w0);
        rd_ptr_next  = IDX_W'(r0);
        wrapped_next = wrapped_reg;
        wr_en        = 1'b0;
        rd_hit       = 1'b0;

        unique case (op)
            orb_pkg::OP_WRITE: begin
                if (enabled_reg) begin
                    wr_en = 1'b1;
                    if (wrapped_reg && (w_inc >= r0)) begin
                        wrapped_next = 1'b0;
                        rd_ptr_next  = IDX_W'(w0);
                    end
                    if (w_inc >= n) begin
                        wrapped_next = 1'b1;
                        wr_ptr_next  = '0;
                    end else begin
                        wr_ptr_next  = IDX_W'(w_inc);
                    end
                end
            end
            orb_pkg::OP_READ: begin
                if (enabled_reg && unread) begin
                    rd_hit = 1'b1;
                    if (r_inc >= n) begin
                        rd_ptr_next  = '0;
                        wrapped_next = 1'b0;
                    end else begin
                        rd_ptr_next  = IDX_W'(r_inc);
                    end
                end
            end
            orb_pkg::OP_SKIP: begin
                if (unread) begin
                    if (w0 == '0) begin
                        wrapped_next = 1'b1;
                        rd_ptr_next  = IDX_W'(n - CMP_W'(1));
                    end else begin
                        wrapped_next = 1'b0;
                        rd_ptr_next  = IDX_W'(w0 - CMP_W'(1));
                    end
                end
            end
            orb_pkg::OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            wrapped_reg    <= 1'b0;
            used_depth_reg <= orb_pkg::USED_DEPTH_RST;
            enabled_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                orb_pkg::REG_USED_DEPTH: begin
                    used_depth_reg <= cfg_wr_data[orb_pkg::USED_DEPTH_W-1:0];
                    wr_ptr_reg     <= '0;
                    rd_ptr_reg     <= '0;
                    wrapped_reg    <= 1'b0;
                end
                orb_pkg::REG_ENABLED: begin
                    enabled_reg <= cfg_wr_data[0];
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            wrapped_reg <= wrapped_next;
        end
    end

    assign mem_req.wr_en   = accept && wr_en;
    assign mem_req.wr_addr = IDX_W'(w0);
    assign mem_req.rd_addr = IDX_W'(r0);
    assign mem_req.rd_hit  = rd_hit;

endmodule

### design/overwriting_ring_buffer.sv
// Overwriting ring buffer top level: request channel, word RAM and result register.
// For each request the ring entry is read from a registered-read RAM in the cycle
// the request is taken; its result enters the output register once that register is
// free or draining. A new request is taken once that load happens, so a result
// may wait on m_tready while the next request is already accepted; a result stalled
// with the previous one still waiting holds the input off. Every request yields one
// result: a read of an unread word returns it with the valid flag set, all other
// requests return zero data with the flag clear. Writes are not refused on a full
// ring; they drop the oldest words. Configuration writes are meant for idle time.
`include "overwriting_ring_buffer_defines.svh"

module overwriting_ring_buffer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [orb_pkg::TDATA_W-1:0]         s_tdata,   // data_in
    input  logic [1:0]                          s_tuser,   // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [orb_pkg::TDATA_W-1:0]         m_tdata,   // data_out
    output logic [0:0]                          m_tuser,   // valid_res
    input  logic                                cfg_wr_en,
    input  logic [orb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [orb_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    localparam int DW = orb_pkg::DATA_WIDTH;

    orb_pkg::orb_mem_req_t mem_req;
    logic                  accept;
    logic [DW-1:0]         rd_data;
    logic                  busy_reg;
    logic                  hit_reg;
    logic                  out_valid_reg;
    logic [DW-1:0]         out_data_reg;
    logic                  out_flag_reg;
    logic                  load;

    assign accept = s_tvalid && s_tready;
    assign s_tready = !busy_reg;
    assign load = busy_reg && (!out_valid_reg || m_tready);

    orb_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .op          (orb_pkg::op_t'(s_tuser)),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .mem_req     (mem_req)
    );

    orb_ram #(
        .WIDTH (DW),
        .DEPTH (orb_pkg::DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (s_tdata[DW-1:0]),
        .rd_en   (accept),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                busy_reg <= 1'b1;
                hit_reg  <= mem_req.rd_hit;
            end else if (load) begin
                busy_reg <= 1'b0;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= hit_reg ? rd_data : '0;
                out_flag_reg  <= hit_reg;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = orb_pkg::TDATA_W'(out_data_reg);
    assign m_tuser  = out_flag_reg;

    `ORB_ASSERT(a_miss_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == '0, "miss result carries data")
    `ORB_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, accept, !s_tready, "request taken while busy")
    `ORB_ASSERT(a_hit_is_read, aclk, aresetn, accept && mem_req.rd_hit, s_tuser == orb_pkg::OP_READ, "hit on non-read")

endmodule
